// ===== sv/lisou_pkg.sv =====
package lisou_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam logic [15:0] THR_RESET = 16'd655;

    localparam int SQ_W    = 64;
    localparam int ROOT_W  = 32;
    localparam int MAG_W   = 64;
    localparam int NUM_W   = 96;
    localparam int QUO_W   = 32;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic             sgn;
        logic             par;
    } t_meta;

    typedef struct packed {
        t_meta            meta;
        logic [MAG_W-1:0] amag;
        logic [MAG_W-1:0] dmag;
    } t_geo;

    typedef struct packed {
        logic [31:0]      offset;
        logic             par;
        logic             sat;
    } t_res;

endpackage

// ===== sv/lisou_sqrt.sv =====
module lisou_sqrt #(
    parameter int PW = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_v,
    input  logic [lisou_pkg::SQ_W-1:0] i_x,
    input  logic [PW-1:0]             i_pay,
    output logic                      o_v,
    output logic [lisou_pkg::ROOT_W-1:0] o_root,
    output logic [PW-1:0]             o_pay
);
    import lisou_pkg::*;

    localparam int NST = ROOT_W;

    logic            r_v   [0:NST-1];
    logic [SQ_W-1:0] r_x   [0:NST-1];
    logic [SQ_W-1:0] r_r   [0:NST-1];
    logic [PW-1:0]   r_pay [0:NST-1];

    for (genvar k = 0; k < NST; k++) begin : g_st
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        logic            v_in;
        logic [SQ_W-1:0] x_in;
        logic [SQ_W-1:0] rt_in;
        logic [PW-1:0]   p_in;
        logic [SQ_W-1:0] trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign v_in  = i_v;
            assign x_in  = i_x;
            assign rt_in = '0;
            assign p_in  = i_pay;
        end else begin : g_next
            assign v_in  = r_v[k-1];
            assign x_in  = r_x[k-1];
            assign rt_in = r_r[k-1];
            assign p_in  = r_pay[k-1];
        end

        assign trial = rt_in + BIT;
        assign ge    = x_in >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]   <= ge ? x_in - trial : x_in;
                r_r[k]   <= ge ? (rt_in >> 1) + BIT : rt_in >> 1;
                r_pay[k] <= p_in;
            end
        end
    end

    assign o_v    = r_v[NST-1];
    assign o_root = r_r[NST-1][ROOT_W-1:0];
    assign o_pay  = r_pay[NST-1];

endmodule

// ===== sv/lisou_div.sv =====
module lisou_div #(
    parameter int PW = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_v,
    input  logic [lisou_pkg::NUM_W-1:0] i_num,
    input  logic [lisou_pkg::MAG_W-1:0] i_den,
    input  logic [PW-1:0]               i_pay,
    output logic                        o_v,
    output logic [lisou_pkg::QUO_W-1:0] o_quo,
    output logic                        o_big,
    output logic [PW-1:0]               o_pay
);
    import lisou_pkg::*;

    localparam int NST = QUO_W + 1;

    logic             r_v   [0:NST-1];
    logic [MAG_W-1:0] r_rem [0:NST-1];
    logic [QUO_W-1:0] r_lo  [0:NST-1];
    logic [QUO_W-1:0] r_q   [0:NST-1];
    logic [MAG_W-1:0] r_d   [0:NST-1];
    logic             r_big [0:NST-1];
    logic [PW-1:0]    r_pay [0:NST-1];

    // quotient of 2^32 or more is flagged up front, then one bit per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num[NUM_W-1:QUO_W];
            r_lo[0]  <= i_num[QUO_W-1:0];
            r_q[0]   <= '0;
            r_d[0]   <= i_den;
            r_big[0] <= i_num[NUM_W-1:QUO_W] >= i_den;
            r_pay[0] <= i_pay;
        end
    end

    for (genvar k = 1; k < NST; k++) begin : g_st
        logic [MAG_W:0] trial;
        logic           ge;
        logic [MAG_W:0] diff;

        assign trial = {r_rem[k-1], r_lo[k-1][QUO_W-k]};
        assign ge    = trial >= {1'b0, r_d[k-1]};
        assign diff  = trial - {1'b0, r_d[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                r_lo[k]  <= r_lo[k-1];
                r_q[k]   <= {r_q[k-1][QUO_W-2:0], ge};
                r_d[k]   <= r_d[k-1];
                r_big[k] <= r_big[k-1];
                r_pay[k] <= r_pay[k-1];
            end
        end
    end

    assign o_v   = r_v[NST-1];
    assign o_quo = r_q[NST-1];
    assign o_big = r_big[NST-1];
    assign o_pay = r_pay[NST-1];

endmodule

// ===== sv/line_intersection_signed_offset_unit.sv =====
// Intersects a base line (point, direction) with a neighbour line and returns the signed
// distance from the base point to the crossing along the base direction, in signed
// fixed point with FRAC_BITS fraction bits, saturated to 32 bits. A new item can be
// taken every cycle while o_ready is high; each item passes through three stages of
// differences, products and sums, a 32-stage square root, two product stages and a
// 33-stage divider, whose last stage feeds a two-entry output buffer. The input stalls
// only while both buffer entries hold results; one waiting result keeps it open. Lines
// whose twice-area sum is below the threshold register (scaled like the inputs) give
// offset 0 with the parallel flag set.
module line_intersection_signed_offset_unit #(
    parameter int FRAC_BITS = lisou_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_mode,
    input  logic signed [31:0] i_base_point_x,
    input  logic signed [31:0] i_base_point_y,
    input  logic signed [31:0] i_base_dir_x,
    input  logic signed [31:0] i_base_dir_y,
    input  logic signed [31:0] i_other_point_x,
    input  logic signed [31:0] i_other_point_y,
    input  logic signed [31:0] i_other_dir_x,
    input  logic signed [31:0] i_other_dir_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_signed_offset,
    output logic               o_parallel_flag,
    output logic               o_saturated_flag,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata
);
    import lisou_pkg::*;

    logic        en;
    logic [15:0] r_thr;

    logic               r1_v, r1_mode;
    logic signed [31:0] r1_bx, r1_by, r1_ox, r1_oy;
    logic signed [32:0] r1_dx, r1_dy;

    logic               r2_v, r2_mode;
    logic signed [64:0] r2_p1, r2_p2;
    logic signed [63:0] r2_p3, r2_p4, r2_sx, r2_sy;

    logic               r3_v, r3_mode;
    logic signed [65:0] r3_a;
    logic signed [64:0] r3_d;
    logic [SQ_W-1:0]    r3_s;

    logic               aneg, dneg;
    logic [65:0]        a_neg_v;
    logic [64:0]        d_neg_v;
    logic [MAG_W-1:0]   thr_ext;
    t_geo               geo_in, geo_out;
    logic               sq_v;
    logic [ROOT_W-1:0]  root;

    logic               r5_v, r6_v;
    t_meta              r5_meta, r6_meta;
    logic [MAG_W-1:0]   r5_d, r6_d;
    logic [63:0]        r5_pl, r5_ph;
    logic [NUM_W-1:0]   r6_n;

    logic               dv_v, dv_big;
    logic [QUO_W-1:0]   dv_q;
    t_meta              dv_meta;
    logic               neg;
    t_res               res;

    logic [1:0]         r_cnt;
    t_res               r_e0, r_e1;
    logic               push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    assign en      = r_cnt != 2'd2;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r5_v <= sq_v;
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mode <= i_mode;
            r1_bx   <= i_base_dir_x;
            r1_by   <= i_base_dir_y;
            r1_ox   <= i_other_dir_x;
            r1_oy   <= i_other_dir_y;
            r1_dx   <= {i_base_point_x[31], i_base_point_x}
                     - {i_other_point_x[31], i_other_point_x};
            r1_dy   <= {i_base_point_y[31], i_base_point_y}
                     - {i_other_point_y[31], i_other_point_y};

            r2_mode <= r1_mode;
            r2_p1   <= r1_ox * r1_dy;
            r2_p2   <= r1_oy * r1_dx;
            r2_p3   <= r1_oy * r1_bx;
            r2_p4   <= r1_ox * r1_by;
            r2_sx   <= r1_bx * r1_bx;
            r2_sy   <= r1_by * r1_by;

            r3_mode <= r2_mode;
            r3_a    <= {r2_p1[64], r2_p1} - {r2_p2[64], r2_p2};
            r3_d    <= {r2_p3[63], r2_p3} - {r2_p4[63], r2_p4};
            r3_s    <= $unsigned(r2_sx) + $unsigned(r2_sy);
        end
    end

    // magnitudes, sign rule and parallel test
    assign aneg    = r3_a[65];
    assign dneg    = r3_d[64];
    assign a_neg_v = -r3_a;
    assign d_neg_v = -r3_d;
    assign thr_ext = MAG_W'(r_thr) << (FRAC_BITS + 1);

    always_comb begin
        geo_in.amag     = aneg ? a_neg_v[MAG_W-1:0] : r3_a[MAG_W-1:0];
        geo_in.dmag     = dneg ? d_neg_v[MAG_W-1:0] : r3_d[MAG_W-1:0];
        geo_in.meta.sgn = (aneg != dneg) != r3_mode;
        geo_in.meta.par = (geo_in.dmag == '0) || (geo_in.dmag < thr_ext);
    end

    lisou_sqrt #(
        .PW($bits(t_geo))
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_v    (r3_v),
        .i_x    (r3_s),
        .i_pay  (geo_in),
        .o_v    (sq_v),
        .o_root (root),
        .o_pay  (geo_out)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_meta <= geo_out.meta;
            r5_d    <= geo_out.dmag;
            r5_pl   <= geo_out.amag[31:0] * root;
            r5_ph   <= geo_out.amag[63:32] * root;

            r6_meta <= r5_meta;
            r6_d    <= r5_d;
            r6_n    <= {32'd0, r5_pl} + {r5_ph, 32'd0};
        end
    end

    lisou_div #(
        .PW($bits(t_meta))
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_v    (r6_v),
        .i_num  (r6_n),
        .i_den  (r6_d),
        .i_pay  (r6_meta),
        .o_v    (dv_v),
        .o_quo  (dv_q),
        .o_big  (dv_big),
        .o_pay  (dv_meta)
    );

    // sign, saturation and parallel override
    always_comb begin
        neg = dv_meta.sgn && (dv_big || (dv_q != '0));
        res = '0;
        if (dv_meta.par) begin
            res.par = 1'b1;
        end else if (dv_big || (neg ? dv_q > SAT_NEG : dv_q > SAT_POS)) begin
            res.offset = neg ? SAT_NEG : SAT_POS;
            res.sat    = 1'b1;
        end else begin
            res.offset = neg ? -dv_q : dv_q;
        end
    end

    // output buffer
    assign push = en && dv_v;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_cnt)
            2'd0: begin
                if (push) begin
                    r_e0 <= res;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    r_e0 <= res;
                end else if (push) begin
                    r_e1 <= res;
                end
            end
            default: begin
                if (pop) begin
                    r_e0 <= r_e1;
                end
            end
        endcase
    end

    assign o_valid          = r_cnt != 2'd0;
    assign o_signed_offset  = r_e0.offset;
    assign o_parallel_flag  = r_e0.par;
    assign o_saturated_flag = r_e0.sat;

    a_par_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_parallel_flag |-> o_signed_offset == '0 && !o_saturated_flag)
        else $error("parallel result not zero");

    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated_flag |->
            o_signed_offset == SAT_POS || o_signed_offset == SAT_NEG)
        else $error("saturated result off the rails");

    a_buf_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer overflow");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 && !i_ready |=> r_cnt == 2'd2)
        else $error("buffer changed while full and stalled");

endmodule
